>>> sv/mstp_pkg.sv
// ----------------------------------------------------------------------------
// mstp_pkg
// Shared types and constants for the prim spanning tree block.
// ----------------------------------------------------------------------------
package mstp_pkg;

  localparam int ROW_W    = 4;
  localparam int COL_W    = 4;
  localparam int COST_W   = 16;
  localparam int NODE_W   = 4;
  localparam int TOTAL_W  = 20;
  localparam int NCOUNT_W = 5;
  localparam int APB_AW   = 2;
  localparam int APB_DW   = 32;

  localparam logic [TOTAL_W-1:0]  TOTAL_MAX        = {TOTAL_W{1'b1}};
  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = 5'd16;
  localparam logic [APB_AW-1:0]   REG_NODE_COUNT   = 2'd0;

  // controller to datapath
  typedef struct packed {
    logic load;         // write the current beat into the weight store
    logic run_init;     // fresh flags, keys and sum, root joins
    logic idx_clr;      // restart the vertex counter
    logic relax_issue;  // read one weight of the new vertex's row
    logic scan_init;    // start a minimum search
    logic scan_en;      // examine one vertex in the search
    logic take;         // join the chosen vertex and emit its edge
    logic emit_disc;    // emit the disconnected result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_last;
    logic found;
    logic final_join;
  } sts_t;

endpackage

>>> sv/mstp_regs.sv
// ----------------------------------------------------------------------------
// mstp_regs
// APB register file holding the vertex count.
// ----------------------------------------------------------------------------
module mstp_regs import mstp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  output logic [NCOUNT_W-1:0] node_count
);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr == REG_NODE_COUNT) begin
      node_count <= pwdata[NCOUNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr == REG_NODE_COUNT) begin
      prdata = {{(APB_DW-NCOUNT_W){1'b0}}, node_count};
    end else begin
      prdata = '0;
    end
  end

  assign pready = 1'b1;

endmodule

>>> sv/mstp_ctrl.sv
// ----------------------------------------------------------------------------
// mstp_ctrl
// Sequencer for loading, relaxing a row and searching the minimum key.
// ----------------------------------------------------------------------------
module mstp_ctrl import mstp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic last,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RELAX  = 3'd1;
  localparam logic [2:0] S_SINIT  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last) begin
            cmd.run_init = 1'b1;
            cmd.idx_clr  = 1'b1;
            state_next   = S_RELAX;
          end
        end
      end
      S_RELAX: begin
        cmd.relax_issue = 1'b1;
        if (sts.idx_last) begin
          state_next = S_SINIT;
        end
      end
      // last weight of the row is written back during this cycle
      S_SINIT: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.idx_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.found) begin
          cmd.emit_disc = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.take = 1'b1;
          if (sts.final_join) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_clr = 1'b1;
            state_next  = S_RELAX;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

>>> sv/mstp_dpath.sv
// ----------------------------------------------------------------------------
// mstp_dpath
// Weight store, key and parent registers, minimum search and tree totals.
// ----------------------------------------------------------------------------
module mstp_dpath import mstp_pkg::*; #(
  parameter int MAX_NODES = 16,
  parameter int COST_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [NCOUNT_W-1:0] node_count,
  input  logic [ROW_W-1:0]    row,
  input  logic [COL_W-1:0]    col,
  input  logic [COST_W-1:0]   cost,
  output logic                strobe,
  output logic [NODE_W-1:0]   child,
  output logic [NODE_W-1:0]   parent_node,
  output logic [COST_W-1:0]   edge_cost,
  output logic [TOTAL_W-1:0]  total_cost,
  output logic                connected,
  output logic                end_of_run
);

  localparam int DEPTH  = MAX_NODES * MAX_NODES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int KEY_W  = COST_BITS + 1;
  localparam int SUM_XW = TOTAL_W + COST_BITS;
  localparam logic [KEY_W-1:0] KEY_INF = {1'b1, {COST_BITS{1'b0}}};

  logic [COST_BITS-1:0] mem [DEPTH];
  logic [COST_BITS-1:0] rd_q;

  logic [MAX_NODES-1:0] in_tree;
  logic [MAX_NODES-1:0] keyed;
  logic [KEY_W-1:0]     key [MAX_NODES];
  logic [IDX_W-1:0]     par [MAX_NODES];

  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     u;
  logic [IDX_W-1:0]     best_par;
  logic [KEY_W-1:0]     best;
  logic                 found;
  logic [CNT_W-1:0]     joined;
  logic [TOTAL_W-1:0]   sum;
  logic                 rel_v;
  logic [IDX_W-1:0]     rel_i;

  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     n_m1;
  logic                 wr_ok;
  logic [ADDR_W-1:0]    waddr;
  logic [ADDR_W-1:0]    raddr;
  logic [COST_BITS-1:0] cost_m;
  logic [KEY_W-1:0]     eff_key;
  logic                 better;
  logic                 relax_hit;
  logic [SUM_XW-1:0]    sum_x;
  logic [TOTAL_W-1:0]   sum_next;
  logic [31:0]          u_ext;
  logic [31:0]          par_ext;
  logic [31:0]          best_ext;

  // vertex count saturated into the supported range
  always_comb begin
    if (32'(node_count) > MAX_NODES) begin
      n = CNT_W'(MAX_NODES);
    end else if (node_count < NCOUNT_W'(2)) begin
      n = CNT_W'(2);
    end else begin
      n = CNT_W'(node_count);
    end
  end

  assign n_m1   = n - CNT_W'(1);
  assign cost_m = COST_BITS'(cost);
  assign wr_ok  = (32'(row) < MAX_NODES) && (32'(col) < MAX_NODES);
  assign waddr  = ADDR_W'(32'(row) * MAX_NODES + 32'(col));
  assign raddr  = ADDR_W'(32'(u) * MAX_NODES + 32'(idx));

  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) begin
      mem[waddr] <= cost_m;
    end
    rd_q <= mem[raddr];
  end

  assign eff_key   = keyed[idx] ? key[idx] : KEY_INF;
  assign better    = !in_tree[idx] && (eff_key < best);
  assign relax_hit = rel_v && (rd_q != '0) && !in_tree[rel_i] &&
                     (!keyed[rel_i] || ({1'b0, rd_q} < key[rel_i]));

  assign sum_x = SUM_XW'(sum) + SUM_XW'(best[COST_BITS-1:0]);
  assign sum_next = (sum_x > SUM_XW'(TOTAL_MAX)) ? TOTAL_MAX : sum_x[TOTAL_W-1:0];

  assign u_ext    = 32'(u);
  assign par_ext  = 32'(best_par);
  assign best_ext = 32'(best[COST_BITS-1:0]);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_tree <= '0;
      keyed   <= '0;
      rel_v   <= 1'b0;
      strobe  <= 1'b0;
      found   <= 1'b0;
      joined  <= '0;
      idx     <= '0;
    end else begin
      rel_v  <= cmd.relax_issue;
      strobe <= cmd.take || cmd.emit_disc;
      if (cmd.run_init) begin
        // only the root is in the tree
        in_tree <= MAX_NODES'(1);
        keyed   <= '0;
        joined  <= CNT_W'(1);
      end else begin
        if (relax_hit) begin
          keyed[rel_i] <= 1'b1;
        end
        if (cmd.take) begin
          in_tree[u] <= 1'b1;
          joined     <= joined + CNT_W'(1);
        end
      end
      if (cmd.scan_init) begin
        found <= 1'b0;
      end else if (cmd.scan_en && better) begin
        found <= 1'b1;
      end
      if (cmd.idx_clr || cmd.scan_init) begin
        idx <= '0;
      end else if (cmd.relax_issue || cmd.scan_en) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rel_i <= idx;
    if (relax_hit) begin
      key[rel_i] <= {1'b0, rd_q};
      par[rel_i] <= u;
    end
    if (cmd.run_init) begin
      u   <= '0;
      sum <= '0;
    end else if (cmd.scan_en && better) begin
      u <= idx;
    end
    if (cmd.scan_init) begin
      best <= KEY_INF;
    end else if (cmd.scan_en && better) begin
      best     <= eff_key;
      best_par <= par[idx];
    end
    if (cmd.take) begin
      sum         <= sum_next;
      child       <= u_ext[NODE_W-1:0];
      parent_node <= par_ext[NODE_W-1:0];
      edge_cost   <= best_ext[COST_W-1:0];
      total_cost  <= sum_next;
      connected   <= 1'b1;
      end_of_run  <= sts.final_join;
    end else if (cmd.emit_disc) begin
      child       <= '0;
      parent_node <= '0;
      edge_cost   <= '0;
      total_cost  <= sum;
      connected   <= 1'b0;
      end_of_run  <= 1'b1;
    end
  end

  assign sts.idx_last   = (idx == n_m1[IDX_W-1:0]);
  assign sts.found      = found;
  assign sts.final_join = (joined == n_m1);

endmodule

>>> sv/minimum_spanning_tree_prim.sv
// ----------------------------------------------------------------------------
// minimum_spanning_tree_prim
// Prim spanning tree over a loaded adjacency matrix, one result per tree edge.
//
//   channel   direction  beat marker             payload
//   apb       in         psel/penable/pwrite     paddr, pwdata (node_count)
//   item      in         start && !busy          row, col, cost, last
//   result    out        strobe                  child, parent_node, edge_cost,
//                                                total_cost, connected, end_of_run
//
// a beat without last is written to the weight store. with last, the root
// and every joining vertex but the final one get row relaxation, a drain
// step, a minimum search and a decision step, in that order, while busy
// stays high; a disconnected graph ends the run early. the weight store has a
// single read port and the search examines one vertex a cycle. results
// appear for one cycle each and cannot be stalled. synchronous reset clears
// the control state; the weight store holds whatever was last written.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_prim import mstp_pkg::*; #(
  parameter int MAX_NODES = 16,
  parameter int COST_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                start,
  output logic                busy,
  input  logic [ROW_W-1:0]    row,
  input  logic [COL_W-1:0]    col,
  input  logic [COST_W-1:0]   cost,
  input  logic                last,
  output logic                strobe,
  output logic [NODE_W-1:0]   child,
  output logic [NODE_W-1:0]   parent_node,
  output logic [COST_W-1:0]   edge_cost,
  output logic [TOTAL_W-1:0]  total_cost,
  output logic                connected,
  output logic                end_of_run
);

  cmd_t                cmd;
  sts_t                sts;
  logic [NCOUNT_W-1:0] node_count;

  mstp_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .node_count (node_count)
  );

  mstp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (last),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  mstp_dpath #(
    .MAX_NODES (MAX_NODES),
    .COST_BITS (COST_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .node_count  (node_count),
    .row         (row),
    .col         (col),
    .cost        (cost),
    .strobe      (strobe),
    .child       (child),
    .parent_node (parent_node),
    .edge_cost   (edge_cost),
    .total_cost  (total_cost),
    .connected   (connected),
    .end_of_run  (end_of_run)
  );

endmodule

>>> sv/mstp_checker.sv
// ----------------------------------------------------------------------------
// mstp_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module mstp_checker import mstp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              last,
  input logic              strobe,
  input logic [NODE_W-1:0] child,
  input logic              connected,
  input logic              end_of_run
);

  // more edges to come keeps the block busy
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    strobe && !end_of_run |-> busy)
    else $error("result mid-run while not busy");

  a_idle_at_end: assert property (@(posedge clk) disable iff (rst)
    strobe && end_of_run |-> !busy)
    else $error("still busy on the final result");

  a_disc_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && !connected |-> end_of_run)
    else $error("disconnected result does not end the run");

  // the root never appears as a child
  a_no_root_child: assert property (@(posedge clk) disable iff (rst)
    strobe && connected |-> child != '0)
    else $error("root reported as child");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !last |=> !strobe)
    else $error("result after a plain load beat");

endmodule

bind minimum_spanning_tree_prim mstp_checker u_mstp_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .last       (last),
  .strobe     (strobe),
  .child      (child),
  .connected  (connected),
  .end_of_run (end_of_run)
);
